[rtl/core/psd_pkg.sv]
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants and codes for the periodic slot dispatcher.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int SLOT_W    = 4;
  localparam int CNT_W     = 5;
  localparam int PER_W     = 26;
  localparam int TICK_W    = 32;
  localparam int TICK_US   = 100;

  // reciprocal of the tick length, exact for every 32-bit dividend
  localparam logic [TICK_W-1:0] DIV_MAGIC = 32'h51EB_851F;
  localparam int                DIV_SHIFT = 37;

  typedef enum logic [1:0] {
    EV_FIRE     = 2'd0,
    EV_MISS     = 2'd1,
    EV_LOAD_OK  = 2'd2,
    EV_LOAD_REJ = 2'd3
  } event_e;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_LOAD = 1'b1
  } func_e;

endpackage

[rtl/core/periodic_slot_dispatcher.sv]
// load transaction: result registered after acceptance through ST_DIV (reciprocal multiply
//   by the tick length) and ST_LOAD_WR (remainder check and write); ready again with the result
// tick transaction: last result registered after the walk over min(active_slots, 16) slots,
//   one slot per cycle through the shared subtract/compare/add unit unless a due slot waits on a full output
// output stalls lengthen both; not ready while a transaction is in work
// reset clears the slot table, active_slots, the state, the pending flag and out_valid at once
// ----------------------------------------------------------------------------
// periodic_slot_dispatcher
// Table of periodic slots: loads slot periods, walks due slots on each tick
// and reports fire, deadline miss and load status.
// ----------------------------------------------------------------------------
module periodic_slot_dispatcher
  import psd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CNT_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  logic [TICK_W-1:0]   now_i,
  input  logic [SLOT_W-1:0]   slot_index_i,
  input  logic [TICK_W-1:0]   load_usec_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SLOT_W-1:0]   slot_number_o,
  output logic [1:0]          event_res_o,
  output logic                last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD_WR,
    ST_SCAN
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    active_q;
  logic [PER_W-1:0]    per_q  [MAX_SLOTS];
  logic [TICK_W-1:0]   next_q [MAX_SLOTS];

  logic [TICK_W-1:0]   now_q;
  logic [SLOT_W-1:0]   idx_q;
  logic [TICK_W-1:0]   div_q;
  logic [PER_W-1:0]    quo_q;
  logic                pus_nz_q;
  logic [CNT_W-1:0]    step_q;
  logic [CNT_W-1:0]    lim_q;

  logic                pend_q;
  logic [SLOT_W-1:0]   pend_slot_q;
  event_e              pend_ev_q;

  logic                out_valid_q;
  logic [SLOT_W-1:0]   out_slot_q;
  event_e              out_ev_q;
  logic                out_last_q;

  logic                out_free;
  logic                in_acc;
  logic [2*TICK_W-1:0] prod;
  logic [PER_W-1:0]    quo_d;
  logic [TICK_W-1:0]   quo_x100;
  logic                load_ok;
  logic [TICK_W-1:0]   load_next;
  logic [SLOT_W-1:0]   scan_idx;
  logic [TICK_W-1:0]   cur_next;
  logic [TICK_W-1:0]   cur_per;
  logic [TICK_W-1:0]   diff;
  logic                due;
  logic                late;
  logic [TICK_W-1:0]   new_next;
  logic [CNT_W-1:0]    lim_d;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // divide by the tick length through a reciprocal multiply
  assign prod     = (2*TICK_W)'(div_q) * (2*TICK_W)'(DIV_MAGIC);
  assign quo_d    = PER_W'(prod >> DIV_SHIFT);
  assign quo_x100 = {{(TICK_W-PER_W){1'b0}}, quo_q} * TICK_W'(TICK_US);

  assign load_ok   = ({1'b0, idx_q} < CNT_W'(MAX_SLOTS)) && pus_nz_q && (quo_x100 == div_q);
  assign load_next = now_q + {{(TICK_W-PER_W){1'b0}}, quo_q};

  // scan unit
  assign scan_idx = step_q[SLOT_W-1:0];
  assign cur_next = next_q[scan_idx];
  assign cur_per  = {{(TICK_W-PER_W){1'b0}}, per_q[scan_idx]};
  assign diff     = now_q - cur_next;
  assign due      = !diff[TICK_W-1];
  assign late     = (diff >= cur_per);
  assign new_next = late ? (now_q + cur_per) : (cur_next + cur_per);

  assign lim_d = (active_q > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < MAX_SLOTS; k++) begin
        per_q[k]  <= '0;
        next_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            now_q    <= now_i;
            idx_q    <= slot_index_i;
            div_q    <= load_usec_i;
            pus_nz_q <= (load_usec_i != '0);
            step_q   <= '0;
            lim_q    <= lim_d;
            if (func_i == FUNC_LOAD) begin
              state_q <= ST_DIV;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_DIV: begin
          quo_q   <= quo_d;
          state_q <= ST_LOAD_WR;
        end
        ST_LOAD_WR: begin
          if (out_free) begin
            if (load_ok) begin
              per_q[idx_q]  <= quo_q;
              next_q[idx_q] <= load_next;
            end
            out_valid_q <= 1'b1;
            out_slot_q  <= idx_q;
            out_ev_q    <= load_ok ? EV_LOAD_OK : EV_LOAD_REJ;
            out_last_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (step_q == lim_q) begin
            if (!pend_q) begin
              state_q <= ST_IDLE;
            end else if (out_free) begin
              out_valid_q <= 1'b1;
              out_slot_q  <= pend_slot_q;
              out_ev_q    <= pend_ev_q;
              out_last_q  <= 1'b1;
              pend_q      <= 1'b0;
              state_q     <= ST_IDLE;
            end
          end else if (!due) begin
            step_q <= step_q + CNT_W'(1);
          end else if (!pend_q || out_free) begin
            next_q[scan_idx] <= new_next;
            if (pend_q) begin
              out_valid_q <= 1'b1;
              out_slot_q  <= pend_slot_q;
              out_ev_q    <= pend_ev_q;
              out_last_q  <= 1'b0;
            end
            pend_q      <= 1'b1;
            pend_slot_q <= scan_idx;
            pend_ev_q   <= late ? EV_MISS : EV_FIRE;
            step_q      <= step_q + CNT_W'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign slot_number_o = out_slot_q;
  assign event_res_o   = out_ev_q;
  assign last_o        = out_last_q;

  // no pending scan result survives into idle
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_q)
    else $error("pending result left in idle");

  // load status is always the final result
  a_load_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_ev_q == EV_LOAD_OK || out_ev_q == EV_LOAD_REJ)) |-> out_last_q)
    else $error("load result without last");

  // scan never runs beyond its limit
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (step_q <= lim_q && lim_q <= CNT_W'(MAX_SLOTS)))
    else $error("scan index out of range");

  // a pending result is held for a slot earlier than the current one
  a_pend_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && pend_q) |-> ({1'b0, pend_slot_q} < step_q))
    else $error("pending slot out of order");

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the periodic slot dispatcher. Loads slot periods and sends
// tick transactions under random idle and stall bursts. A scoreboard keeps
// its own slot table and checks every fire, deadline miss and load status in
// order.
// ----------------------------------------------------------------------------
module tb_top;
  import psd_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    event_e            ev;
    logic              last;
  } slot_event_t;

  class dispatch_scoreboard;
    logic [PER_W-1:0]  period_tab [MAX_SLOTS];
    logic [TICK_W-1:0] next_due_tab [MAX_SLOTS];
    logic [CNT_W-1:0]  active_cnt;
    slot_event_t       due_events [$];
    int errors, fires, misses, loads_ok, loads_rej, ticks;

    function new();
      for (int i = 0; i < MAX_SLOTS; i++) begin
        period_tab[i]   = '0;
        next_due_tab[i] = '0;
      end
      active_cnt = '0;
      errors = 0;
      fires = 0;
      misses = 0;
      loads_ok = 0;
      loads_rej = 0;
      ticks = 0;
    endfunction

    function void set_active(logic [CNT_W-1:0] value);
      active_cnt = value;
    endfunction

    function void predict_events(func_e f, logic [TICK_W-1:0] now,
                                 logic [SLOT_W-1:0] idx, logic [TICK_W-1:0] pus);
      slot_event_t       found [$];
      slot_event_t       e;
      logic [TICK_W-1:0] diff;
      logic [TICK_W-1:0] per;
      int                n;
      if (f == FUNC_LOAD) begin
        e.slot = idx;
        e.last = 1'b1;
        if (pus != 0 && pus % TICK_US == 0) begin
          period_tab[idx]   = PER_W'(pus / TICK_US);
          next_due_tab[idx] = now + TICK_W'(period_tab[idx]);
          e.ev = EV_LOAD_OK;
          loads_ok++;
        end else begin
          e.ev = EV_LOAD_REJ;
          loads_rej++;
        end
        due_events.push_back(e);
      end else begin
        ticks++;
        n = (active_cnt > MAX_SLOTS) ? MAX_SLOTS : int'(active_cnt);
        for (int i = 0; i < n; i++) begin
          diff = now - next_due_tab[i];
          per  = TICK_W'(period_tab[i]);
          // negative difference: slot not yet due
          if (!diff[TICK_W-1]) begin
            e.slot = SLOT_W'(i);
            e.last = 1'b0;
            if (diff >= per) begin
              next_due_tab[i] = now + per;
              e.ev = EV_MISS;
            end else begin
              next_due_tab[i] = next_due_tab[i] + per;
              e.ev = EV_FIRE;
            end
            found.push_back(e);
          end
        end
        if (found.size() > 0) begin
          found[found.size()-1].last = 1'b1;
        end
        foreach (found[k]) begin
          due_events.push_back(found[k]);
        end
      end
    endfunction

    function void match_event(logic [SLOT_W-1:0] slot, logic [1:0] ev, logic last);
      slot_event_t want;
      if (due_events.size() == 0) begin
        $display("%0t: unexpected result, expected none, got slot %0d event %0d last %0b",
                 $time, slot, ev, last);
        errors++;
      end else begin
        want = due_events.pop_front();
        if (want.slot !== slot || want.ev !== ev || want.last !== last) begin
          $display("%0t: mismatch, expected slot %0d event %s last %0b,",
                   $time, want.slot, want.ev.name(), want.last,
                   " got slot %0d event %0d last %0b", slot, ev, last);
          errors++;
        end else if (want.ev == EV_FIRE) begin
          fires++;
        end else if (want.ev == EV_MISS) begin
          misses++;
        end
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  func_e             func_sel = FUNC_TICK;
  logic [TICK_W-1:0] now_val = '0;
  logic [SLOT_W-1:0] slot_idx = '0;
  logic [TICK_W-1:0] load_usec = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SLOT_W-1:0] slot_number;
  logic [1:0]        event_res;
  logic              last_flag;

  bit idle_en = 1'b1;
  bit stall_en = 1'b1;

  dispatch_scoreboard sb;

  always #6 clk_i = ~clk_i;

  periodic_slot_dispatcher u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .func_i        (func_sel),
    .now_i         (now_val),
    .slot_index_i  (slot_idx),
    .load_usec_i   (load_usec),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .slot_number_o (slot_number),
    .event_res_o   (event_res),
    .last_o        (last_flag)
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      sb.match_event(slot_number, event_res, last_flag);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(func_e f, logic [TICK_W-1:0] now, logic [SLOT_W-1:0] idx,
                           logic [TICK_W-1:0] pus);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    func_sel  <= f;
    now_val   <= now;
    slot_idx  <= idx;
    load_usec <= pus;
    do @(posedge clk_i); while (!in_ready);
    sb.predict_events(f, now, idx, pus);
  endtask

  task automatic tick_at(logic [TICK_W-1:0] now);
    send_item(FUNC_TICK, now, SLOT_W'($urandom), $urandom);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.due_events.size() != 0);
  endtask

  // a tick with nothing due leaves no trace, so give the walk time to finish
  task automatic write_active(logic [CNT_W-1:0] value);
    hold_until_drained();
    repeat (40) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_active(value);
  endtask

  task automatic run_phase(int count, logic [CNT_W-1:0] act, bit calm, bit hold_mid);
    logic [TICK_W-1:0] clock_now;
    int                lim;
    int                r;
    write_active(act);
    clock_now = $urandom;
    lim = (act == 0 || act > MAX_SLOTS) ? MAX_SLOTS : int'(act);
    idle_en  = !calm;
    stall_en = !calm;
    for (int i = 0; i < lim; i++) begin
      send_item(FUNC_LOAD, clock_now, SLOT_W'(i), 100 * $urandom_range(1, 20));
    end
    for (int k = 0; k < count; k++) begin
      if (!calm && k % 25 == 0) begin
        idle_en  = ($urandom_range(0, 3) != 0);
        stall_en = ($urandom_range(0, 3) != 0);
      end
      if (hold_mid && k == count / 2) begin
        hold_until_drained();
      end
      r = $urandom_range(0, 99);
      if (r < 15) begin
        send_item(FUNC_LOAD, clock_now, SLOT_W'($urandom_range(0, lim - 1)),
                  100 * $urandom_range(1, 20));
      end else if (r < 20) begin
        send_item(FUNC_LOAD, clock_now, SLOT_W'($urandom), $urandom);
      end else if (r < 23) begin
        send_item(FUNC_LOAD, clock_now, SLOT_W'($urandom),
                  100 * $urandom_range(1, 42949672));
      end else if (r < 26) begin
        tick_at($urandom);
      end else begin
        if ($urandom_range(0, 99) < 85) begin
          clock_now = clock_now + $urandom_range(0, 3);
        end else begin
          clock_now = clock_now + $urandom_range(4, 60);
        end
        tick_at(clock_now);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty scan, unloaded slots, wrap-around compare, load checks
    tick_at(32'h0000_0000);
    write_active(5'd16);
    tick_at(32'h0000_0000);
    tick_at(32'h8000_0000);
    tick_at(32'h7FFF_FFFF);
    send_item(FUNC_LOAD, 32'h0000_1000, 4'd0, 32'd0);
    send_item(FUNC_LOAD, 32'h0000_1000, 4'd1, 32'd150);
    send_item(FUNC_LOAD, 32'h0000_1000, 4'd15, 32'hFFFF_FFFF);
    send_item(FUNC_LOAD, 32'hFFFF_FFFF, 4'd15, 32'd4294967200);
    send_item(FUNC_LOAD, 32'h0000_1000, 4'd0, 32'd100);
    send_item(FUNC_LOAD, 32'h0000_1000, 4'd1, 32'd300);
    tick_at(32'h0000_1001);
    tick_at(32'h0000_1003);
    tick_at(32'h0000_1010);
    send_item(FUNC_LOAD, 32'hFFFF_FFF0, 4'd7, 32'd1000000);
    tick_at(32'h0000_2700);
    write_active(5'd31);
    tick_at(32'h7FFF_0000);
    tick_at(32'hFFFF_FFFF);
    write_active(5'd1);
    tick_at(32'hFFFF_FFFF);
    tick_at(32'h1234_5678);

    run_phase(65, 5'd16, 1'b0, 1'b1);
    run_phase(40, 5'd1, 1'b0, 1'b0);
    run_phase(65, 5'd31, 1'b0, 1'b0);
    run_phase(65, CNT_W'($urandom_range(2, 15)), 1'b0, 1'b0);
    run_phase(20, 5'd0, 1'b0, 1'b0);
    run_phase(85, 5'd16, 1'b1, 1'b0);

    hold_until_drained();
    repeat (40) @(posedge clk_i);
    if (sb.due_events.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.due_events.size());
      sb.errors++;
    end
    $display("Run covered %0d ticks, %0d accepted and %0d rejected loads, active counts 0 to 31",
             sb.ticks, sb.loads_ok, sb.loads_rej);
    $display("Matched %0d fire and %0d deadline-miss events, %0d errors",
             sb.fires, sb.misses, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
